FILE: rtl/core/utf8_to_utf16_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Concurrent assertion wrappers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define U8TO16_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Short form for modules whose clock and reset are clk_i and rst_ni.
`define U8TO16_ASSERT_CLK(lbl, prop, msg) \
  `U8TO16_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/u8to16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and code-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package u8to16_pkg;

  localparam int MaxRes = 4;              // results one byte can cause
  localparam int IdxW   = $clog2(MaxRes);
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int TotalW = 32;

  // Sequence length codes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  // Lead byte ranges
  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;

  // Code point limits
  localparam logic [20:0] MinCp2   = 21'h00080;
  localparam logic [20:0] MinCp3   = 21'h00800;
  localparam logic [20:0] Plane1   = 21'h10000;
  localparam logic [20:0] MaxCp    = 21'h10FFFF;
  localparam logic [20:0] SurFirst = 21'h0D800;
  localparam logic [20:0] SurLast  = 21'h0DFFF;

  localparam logic [15:0] ReplChar = 16'hFFFD;
  localparam logic [15:0] HiSurBase = 16'hD800;
  localparam logic [15:0] LoSurBase = 16'hDC00;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } byte_beat_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        unit_valid;
    logic        status;
  } slot_t;

  // All results of one byte, handed from the decoder to the result buffer
  typedef struct packed {
    slot_t [MaxRes-1:0] slot;
    logic [CntW-1:0]    count;
    logic               last;
    logic [TotalW-1:0]  total;
  } res_pack_t;

  typedef struct packed {
    logic [15:0]       unit;
    logic              unit_valid;
    logic              status;
    logic [TotalW-1:0] units_total;
    logic              last_of_string;
  } res_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/u8to16_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8to16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_string;

  modport source (output valid, output byte_value, output end_of_string, input ready);
  modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

interface u8to16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit;
  logic        unit_valid;
  logic        status;
  logic [31:0] units_total;
  logic        last_of_string;

  modport source (output valid, output unit, output unit_valid, output status,
                  output units_total, output last_of_string, input ready);
  modport sink   (input valid, input unit, input unit_valid, input status,
                  input units_total, input last_of_string, output ready);
endinterface

interface u8to16_cfg_if;
  logic valid;
  logic ready;
  logic lossy;

  modport source (output valid, output lossy, input ready);
  modport sink   (input valid, input lossy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/u8to16_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 input stage
// One-entry input register; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_in_stage (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire u8to16_pkg::byte_beat_t in_beat_i,
  output logic                        in_ready_o,
  input  wire logic                   pop_i,
  output logic                        hold_valid_o,
  output u8to16_pkg::byte_beat_t      hold_beat_o
);

  logic                   valid_q, valid_d;
  u8to16_pkg::byte_beat_t beat_q;
  logic                   fire;

  assign in_ready_o = !valid_q || pop_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      beat_q <= in_beat_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_beat_o  = beat_q;

endmodule

`default_nettype wire

FILE: rtl/core/u8to16_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decode step
// Sequence state and single-pass decode of one byte into up to four results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_decode #(
  parameter int CountWidth = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  input  wire u8to16_pkg::byte_beat_t item_i,
  input  wire logic                   lossy_i,
  input  wire logic                   buf_free_i,
  output logic                        take_o,
  output u8to16_pkg::res_pack_t       pack_o
);

  logic [20:0]           acc_q, acc_d;
  logic [2:0]            exp_q, exp_d;
  logic [2:0]            taken_q, taken_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  skip_q, skip_d;

  logic [7:0]  b;
  logic        eos;
  logic        pend, cont, path_a, path_b, done_a, bad_cp, pair;
  logic [20:0] acc_sh, minv, cp_off;
  logic [2:0]  taken_inc;
  logic        seg1_inv, seg1_cp, relead;
  logic [2:0]  seg1_k;
  logic        is_ascii, is_lead, bad_lead;
  logic [2:0]  lead_len;
  logic [20:0] lead_acc;
  logic        seg2_unit, seg2_inv, err;
  logic [2:0]  n1, n2, n_units, n_all, add;
  logic [15:0] hi_unit, lo_unit;
  logic [CountWidth:0]   sum_w;
  logic [CountWidth-1:0] sat;
  logic [63:0]           sat_wide;

  assign b   = item_i.byte_value;
  assign eos = item_i.end_of_string;

  assign take_o = item_valid_i && buf_free_i;

  always_comb begin
    pend      = exp_q != u8to16_pkg::LenNone;
    cont      = b[7:6] == 2'b10;
    path_a    = pend && cont;
    path_b    = pend && !cont;
    acc_sh    = {acc_q[14:0], b[5:0]};
    taken_inc = taken_q + 3'd1;
    done_a    = taken_inc >= exp_q;

    case (exp_q)
      u8to16_pkg::LenTwo:   minv = u8to16_pkg::MinCp2;
      u8to16_pkg::LenThree: minv = u8to16_pkg::MinCp3;
      default:              minv = u8to16_pkg::Plane1;
    endcase

    bad_cp = (acc_sh < minv) || (acc_sh > u8to16_pkg::MaxCp) ||
             ((acc_sh >= u8to16_pkg::SurFirst) && (acc_sh <= u8to16_pkg::SurLast));
    pair   = acc_sh[20:16] != 5'd0;
    cp_off = acc_sh - u8to16_pkg::Plane1;
    hi_unit = u8to16_pkg::HiSurBase | {6'd0, cp_off[19:10]};
    lo_unit = u8to16_pkg::LoSurBase | {6'd0, cp_off[9:0]};

    seg1_inv = (path_a && ((done_a && bad_cp) || (!done_a && eos))) || path_b;
    seg1_k   = path_a ? taken_inc : taken_q;
    seg1_cp  = path_a && done_a && !bad_cp;
    relead   = !pend || (path_b && lossy_i);

    is_ascii = b <= u8to16_pkg::AsciiMax;
    lead_len = u8to16_pkg::LenNone;
    lead_acc = 21'd0;
    if (b >= u8to16_pkg::Lead2Min && b <= u8to16_pkg::Lead2Max) begin
      lead_len = u8to16_pkg::LenTwo;
      lead_acc = {16'd0, b[4:0]};
    end else if (b >= u8to16_pkg::Lead3Min && b <= u8to16_pkg::Lead3Max) begin
      lead_len = u8to16_pkg::LenThree;
      lead_acc = {17'd0, b[3:0]};
    end else if (b >= u8to16_pkg::Lead4Min && b <= u8to16_pkg::Lead4Max) begin
      lead_len = u8to16_pkg::LenFour;
      lead_acc = {18'd0, b[2:0]};
    end
    is_lead  = lead_len != u8to16_pkg::LenNone;
    bad_lead = !is_ascii && !is_lead;

    seg2_unit = is_ascii;
    seg2_inv  = bad_lead || (is_lead && eos);

    // strict mode: first error is the only result of the byte
    err = !lossy_i && (seg1_inv || (relead && seg2_inv));

    if (seg1_inv) begin
      n1 = seg1_k;
    end else if (seg1_cp) begin
      n1 = pair ? 3'd2 : 3'd1;
    end else begin
      n1 = 3'd0;
    end
    n2      = (relead && (seg2_unit || seg2_inv)) ? 3'd1 : 3'd0;
    n_units = n1 + n2;

    if (skip_q) begin
      n_all = 3'd0;
      add   = 3'd0;
    end else if (err) begin
      n_all = 3'd1;
      add   = 3'd0;
    end else begin
      n_all = n_units;
      add   = n_units;
    end

    sum_w    = {1'b0, cnt_q} + {{(CountWidth-2){1'b0}}, add};
    sat      = sum_w[CountWidth] ? {CountWidth{1'b1}} : sum_w[CountWidth-1:0];
    sat_wide = 64'(sat);
  end

  // Result slots
  always_comb begin
    for (int i = 0; i < u8to16_pkg::MaxRes; i++) begin
      pack_o.slot[i].unit_valid = 1'b1;
      pack_o.slot[i].status     = 1'b0;
      if (err) begin
        pack_o.slot[i].unit       = 16'd0;
        pack_o.slot[i].unit_valid = 1'b0;
        pack_o.slot[i].status     = 1'b1;
      end else if (3'(i) < n1) begin
        if (seg1_inv) begin
          pack_o.slot[i].unit = u8to16_pkg::ReplChar;
        end else if (pair) begin
          pack_o.slot[i].unit = (i == 0) ? hi_unit : lo_unit;
        end else begin
          pack_o.slot[i].unit = acc_sh[15:0];
        end
      end else begin
        pack_o.slot[i].unit = seg2_unit ? {8'd0, b} : u8to16_pkg::ReplChar;
      end
    end
    pack_o.count = n_all;
    pack_o.last  = !skip_q && (eos || err);
    pack_o.total = sat_wide[u8to16_pkg::TotalW-1:0];
  end

  // Next state
  always_comb begin
    acc_d   = acc_q;
    exp_d   = exp_q;
    taken_d = taken_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    if (skip_q) begin
      if (eos) begin
        skip_d = 1'b0;
        cnt_d  = '0;
      end
    end else begin
      if (path_a) begin
        acc_d   = acc_sh;
        taken_d = taken_inc;
        if (done_a || eos) begin
          exp_d = u8to16_pkg::LenNone;
        end
      end
      if (path_b) begin
        exp_d = u8to16_pkg::LenNone;
      end
      if (relead && is_lead) begin
        taken_d = u8to16_pkg::LenOne;
        acc_d   = lead_acc;
        if (!eos) begin
          exp_d = lead_len;
        end
      end
      if (err || eos) begin
        cnt_d   = '0;
        exp_d   = u8to16_pkg::LenNone;
        taken_d = 3'd0;
        acc_d   = 21'd0;
        skip_d  = err && !eos;
      end else begin
        cnt_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 21'd0;
      exp_q   <= u8to16_pkg::LenNone;
      taken_q <= 3'd0;
      cnt_q   <= '0;
      skip_q  <= 1'b0;
    end else if (take_o) begin
      acc_q   <= acc_d;
      exp_q   <= exp_d;
      taken_q <= taken_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8to16_res_buf.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 result buffer
// Holds the results of one byte and hands them out one beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8to16_res_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire u8to16_pkg::res_pack_t pack_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output u8to16_pkg::res_beat_t      out_beat_o
);

  u8to16_pkg::slot_t [u8to16_pkg::MaxRes-1:0] slot_q;
  logic [u8to16_pkg::CntW-1:0]   left_q;
  logic [u8to16_pkg::IdxW-1:0]   idx_q;
  logic                          last_q;
  logic [u8to16_pkg::TotalW-1:0] total_q;
  logic                          fire, final_beat;

  assign out_valid_o = left_q != '0;
  assign fire        = out_valid_o && out_ready_i;
  assign final_beat  = left_q == u8to16_pkg::CntW'(1);
  // free once the buffer is empty or its final beat leaves this cycle
  assign free_o      = (left_q == '0) || (final_beat && out_ready_i);

  always_comb begin
    out_beat_o.unit           = slot_q[idx_q].unit;
    out_beat_o.unit_valid     = slot_q[idx_q].unit_valid;
    out_beat_o.status         = slot_q[idx_q].status;
    out_beat_o.last_of_string = final_beat && last_q;
    out_beat_o.units_total    = (final_beat && last_q) ? total_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      idx_q  <= '0;
    end else if (load_i) begin
      left_q <= pack_i.count;
      idx_q  <= '0;
    end else if (fire) begin
      left_q <= left_q - u8to16_pkg::CntW'(1);
      idx_q  <= idx_q + u8to16_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q  <= pack_i.slot;
      last_q  <= pack_i.last;
      total_q <= pack_i.total;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Validates a UTF-8 byte stream and emits UTF-16 code units per string.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                           beat when
//  byte_i    in   byte_value[7:0], end_of_string                    valid & ready
//  unit_o    out  unit[15:0], unit_valid, status, units_total[31:0],
//                 last_of_string                                    valid & ready
//  cfg_i     in   lossy                                             valid & ready
//
//  One byte per cycle while each byte yields at most one result and unit_o is
//  ready; a byte that yields more results (up to 4) holds the input until the
//  result buffer, draining one beat per cycle while unit_o is ready, frees. The
//  first result of a byte passes the input register and the result buffer first.
//  Reset clears the decode state and both buffers; no clearing pass. A stalled
//  output backs up through the result buffer and the input register to
//  byte_i.ready. cfg_i is always ready.
//
`default_nettype none

module utf8_to_utf16_transcoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8to16_byte_if.sink   byte_i,
  u8to16_unit_if.source unit_o,
  u8to16_cfg_if.sink    cfg_i
);

  // Lossy/strict mode register
  logic mode_q;

  u8to16_pkg::byte_beat_t in_beat, hold_beat;
  logic                   hold_valid, take, buf_free, out_valid;
  u8to16_pkg::res_pack_t  pack;
  u8to16_pkg::res_beat_t  out_beat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.lossy;
    end
  end

  assign in_beat.byte_value    = byte_i.byte_value;
  assign in_beat.end_of_string = byte_i.end_of_string;

  // Input register: part the byte source from the decode step
  u8to16_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_beat_i    (in_beat),
    .in_ready_o   (byte_i.ready),
    .pop_i        (take),
    .hold_valid_o (hold_valid),
    .hold_beat_o  (hold_beat)
  );

  // Decode: advance the sequence state and build all results of a byte
  u8to16_decode #(
    .CountWidth (COUNT_WIDTH)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (hold_valid),
    .item_i       (hold_beat),
    .lossy_i      (mode_q),
    .buf_free_i   (buf_free),
    .take_o       (take),
    .pack_o       (pack)
  );

  // Result buffer: hold the results and drain one beat per cycle while unit_o is ready
  u8to16_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .pack_i      (pack),
    .free_o      (buf_free),
    .out_valid_o (out_valid),
    .out_ready_i (unit_o.ready),
    .out_beat_o  (out_beat)
  );

  assign unit_o.valid          = out_valid;
  assign unit_o.unit           = out_beat.unit;
  assign unit_o.unit_valid     = out_beat.unit_valid;
  assign unit_o.status         = out_beat.status;
  assign unit_o.units_total    = out_beat.units_total;
  assign unit_o.last_of_string = out_beat.last_of_string;

endmodule

`default_nettype wire

FILE: rtl/core/u8to16_chk.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder port checker
// Result channel checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_macros.svh"

module u8to16_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_unit_valid_i,
  input wire logic        out_status_i,
  input wire logic        out_last_i,
  input wire logic [31:0] out_total_i
);

  `U8TO16_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped while stalled")
  `U8TO16_ASSERT_CLK(a_err_last, out_valid_i && out_status_i |-> out_last_i && !out_unit_valid_i, "error beat not final or carries a unit")
  `U8TO16_ASSERT_CLK(a_nounit_err, out_valid_i && !out_unit_valid_i |-> out_status_i, "status-only beat without error")
  `U8TO16_ASSERT_CLK(a_total_last, out_valid_i && !out_last_i |-> out_total_i == 32'd0, "unit count shown before string end")

endmodule

bind utf8_to_utf16_transcoder u8to16_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (unit_o.valid),
  .out_ready_i      (unit_o.ready),
  .out_unit_valid_i (unit_o.unit_valid),
  .out_status_i     (unit_o.status),
  .out_last_i       (unit_o.last_of_string),
  .out_total_i      (unit_o.units_total)
);

`default_nettype wire
